[rtl/set_assoc_cache_lru_model_top_assert.svh]
// Assertion helpers for the cache tag store checker.
`ifndef SET_ASSOC_CACHE_LRU_MODEL_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_MODEL_TOP_ASSERT_SVH

// same-cycle implication
`define SAC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sac_pkg.sv]
package sac_pkg;

    localparam int XADDR_W    = 64;
    localparam int STAMP_W    = 64;
    localparam int TOTAL_W    = 32;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int RAW_SET_W  = 15;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

    typedef struct packed {
        logic [3:0] set_bits;
        logic [5:0] block_bits;
        logic [3:0] ways_used;
    } t_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_WRITE
    } t_back_state;

endpackage

[rtl/sac_if.sv]
interface sac_in_if;
    logic                      valid;
    logic                      ready;
    logic [sac_pkg::OP_W-1:0]  op;
    logic [sac_pkg::XADDR_W-1:0] address;
    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

interface sac_out_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         miss;
    logic                         evicted;
    logic                         last;
    logic [sac_pkg::TOTAL_W-1:0]  hit_total;
    logic [sac_pkg::TOTAL_W-1:0]  miss_total;
    logic [sac_pkg::TOTAL_W-1:0]  eviction_total;
    modport source (output valid, output hit, output miss, output evicted, output last,
                    output hit_total, output miss_total, output eviction_total,
                    input ready);
    modport sink (input valid, input hit, input miss, input evicted, input last,
                  input hit_total, input miss_total, input eviction_total,
                  output ready);
endinterface

interface sac_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sac_pkg::CFG_IDX_W-1:0]   index;
    logic [sac_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/sac_queue.sv]
module sac_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[rtl/sac_front.sv]
module sac_front #(
    parameter int ADDR_WIDTH = 64,
    parameter int MAX_SETS   = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sac_pkg::t_cfg          i_cfg,
    sac_in_if.sink                 i_in,
    input  logic                   i_block,
    output logic                   o_push,
    output logic [ADDR_WIDTH+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1):0] o_push_data,
    input  logic                   i_push_ready
);

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RW        = sac_pkg::RAW_SET_W;
    localparam bit POW2      = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    localparam int MOD_STEPS = POW2 ? 0 : 3;
    localparam int K         = RW + SET_W;
    localparam int PW        = RW + K;
    localparam logic [K-1:0] RECIP = K'((64'd1 << K) / MAX_SETS);

    sac_pkg::t_front_state r_state, n_state;
    logic [RW-1:0]         r_rem;
    logic [RW-1:0]         r_q;
    logic [3:0]            r_cnt;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic                  r_twice;

    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] above;
    logic [6:0]            tag_sh;
    logic [15:0]           set_mask;
    logic [RW-1:0]         raw_set;
    logic [PW-1:0]         prod;
    logic [RW-1:0]         qd;
    logic                  accept;

    assign addr_m   = i_in.address[ADDR_WIDTH-1:0];
    assign above    = addr_m >> i_cfg.block_bits;
    assign tag_sh   = {3'b0, i_cfg.set_bits} + {1'b0, i_cfg.block_bits};
    assign set_mask = (16'd1 << i_cfg.set_bits) - 16'd1;
    assign raw_set  = above[RW-1:0] & set_mask[RW-1:0];
    // reciprocal estimate of the quotient, low by at most one
    assign prod     = PW'(r_rem) * PW'(RECIP);
    assign qd       = r_q * RW'(MAX_SETS);
    assign accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sac_pkg::F_IDLE: begin
                if (accept && i_in.op != sac_pkg::OP_NONE) begin
                    n_state = sac_pkg::F_MOD;
                end
            end
            sac_pkg::F_MOD: begin
                if (r_cnt == 4'd0) begin
                    n_state = sac_pkg::F_PUSH;
                end
            end
            sac_pkg::F_PUSH: begin
                if (i_push_ready) begin
                    n_state = sac_pkg::F_IDLE;
                end
            end
            default: n_state = sac_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == sac_pkg::F_IDLE) && !i_block;
        o_push      = (r_state == sac_pkg::F_PUSH);
        o_push_data = {r_twice, r_tag, SET_W'(r_rem)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sac_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sac_pkg::F_IDLE && accept) begin
            r_tag   <= addr_m >> tag_sh;
            r_twice <= (i_in.op == sac_pkg::OP_MODIFY);
            r_cnt   <= 4'(MOD_STEPS);
            r_rem   <= POW2 ? (raw_set & RW'(MAX_SETS - 1)) : raw_set;
        end else if (r_state == sac_pkg::F_MOD && r_cnt != 4'd0) begin
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd3) begin
                r_q <= prod[PW-1:K];
            end else if (r_cnt == 4'd2) begin
                r_rem <= r_rem - qd;
            end else if (r_rem >= RW'(MAX_SETS)) begin
                r_rem <= r_rem - RW'(MAX_SETS);
            end
        end
    end

endmodule

[rtl/sac_back.sv]
module sac_back #(
    parameter int ADDR_WIDTH = 64,
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sac_pkg::t_cfg          i_cfg,
    input  logic                   i_q_valid,
    input  logic [ADDR_WIDTH+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1):0] i_q_data,
    output logic                   o_pop,
    output logic                   o_clearing,
    sac_out_if.source              o_out
);

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int NUM_LINES = MAX_SETS * MAX_WAYS;
    localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SW        = sac_pkg::STAMP_W;
    localparam int TW        = sac_pkg::TOTAL_W;
    localparam int E_W       = 1 + ADDR_WIDTH + SW;

    logic [E_W-1:0] mem [NUM_LINES];
    logic [E_W-1:0] r_rd_data;

    sac_pkg::t_back_state r_state, n_state;
    logic [LINE_W-1:0]    r_clr;
    logic                 r_pass;
    logic [WAY_CNT_W-1:0] r_rd_way;
    logic [WAY_CNT_W-1:0] r_chk_way;
    logic                 r_rd_vld;
    logic                 r_hit;
    logic [WAY_CNT_W-1:0] r_hit_way;
    logic [WAY_CNT_W-1:0] r_vic_way;
    logic [SW-1:0]        r_vic_stamp;
    logic                 r_vic_valid;
    logic [SW-1:0]        r_stamp_ctr;
    logic [TW-1:0]        r_hits, r_misses, r_evicts;
    logic                 r_ov;
    logic                 r_o_hit, r_o_evict, r_o_last;

    logic [SET_W-1:0]      q_set;
    logic [ADDR_WIDTH-1:0] q_tag;
    logic                  q_twice;
    logic [5:0]            wx;
    logic [WAY_CNT_W-1:0]  ways;
    logic [LINE_W-1:0]     base;
    logic [LINE_W-1:0]     rd_addr;
    logic                  rd_en;
    logic                  rd_valid_bit;
    logic [ADDR_WIDTH-1:0] rd_tag;
    logic [SW-1:0]         rd_stamp;
    logic                  scan_done;
    logic                  out_free;
    logic                  commit;
    logic                  mem_we;
    logic [LINE_W-1:0]     wr_addr;
    logic [E_W-1:0]        wr_data;
    logic [WAY_CNT_W-1:0]  wr_way;

    assign {q_twice, q_tag, q_set} = i_q_data;

    always_comb begin
        wx = 6'(i_cfg.ways_used);
        if (wx == 6'd0) begin
            wx = 6'd1;
        end
        if (wx > 6'(MAX_WAYS)) begin
            wx = 6'(MAX_WAYS);
        end
        ways = WAY_CNT_W'(wx);
    end

    assign base         = LINE_W'(q_set) * LINE_W'(MAX_WAYS);
    assign rd_addr      = base + LINE_W'(r_rd_way);
    assign rd_en        = (r_state == sac_pkg::B_SCAN) && (r_rd_way < ways);
    assign rd_valid_bit = r_rd_data[E_W-1];
    assign rd_tag       = r_rd_data[SW +: ADDR_WIDTH];
    assign rd_stamp     = r_rd_data[SW-1:0];
    assign scan_done    = r_rd_vld && (r_chk_way == ways - WAY_CNT_W'(1));
    assign out_free     = !r_ov || o_out.ready;
    assign commit       = (r_state == sac_pkg::B_WRITE) && out_free;
    assign wr_way       = r_hit ? r_hit_way : r_vic_way;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sac_pkg::B_CLEAR: begin
                if (r_clr == LINE_W'(NUM_LINES - 1)) begin
                    n_state = sac_pkg::B_IDLE;
                end
            end
            sac_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_state = sac_pkg::B_SCAN;
                end
            end
            sac_pkg::B_SCAN: begin
                if (scan_done) begin
                    n_state = sac_pkg::B_WRITE;
                end
            end
            sac_pkg::B_WRITE: begin
                if (out_free) begin
                    n_state = (q_twice && !r_pass) ? sac_pkg::B_SCAN : sac_pkg::B_IDLE;
                end
            end
            default: n_state = sac_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_clearing = (r_state == sac_pkg::B_CLEAR);
        o_pop      = commit && !(q_twice && !r_pass);
        mem_we     = o_clearing || commit;
        wr_addr    = o_clearing ? r_clr : base + LINE_W'(wr_way);
        wr_data    = o_clearing ? '0 : {1'b1, q_tag, r_stamp_ctr};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sac_pkg::B_CLEAR;
            r_clr       <= '0;
            r_stamp_ctr <= SW'(1);
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_ov        <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr <= r_clr + LINE_W'(1);
            end
            if (r_state == sac_pkg::B_IDLE) begin
                r_pass <= 1'b0;
            end
            r_rd_vld <= rd_en;
            if (r_ov && o_out.ready && !commit) begin
                r_ov <= 1'b0;
            end
            if (commit) begin
                r_ov        <= 1'b1;
                r_stamp_ctr <= r_stamp_ctr + SW'(1);
                r_pass      <= 1'b1;
                if (r_hit) begin
                    r_hits <= (r_hits == '1) ? r_hits : r_hits + TW'(1);
                end else begin
                    r_misses <= (r_misses == '1) ? r_misses : r_misses + TW'(1);
                    if (r_vic_valid) begin
                        r_evicts <= (r_evicts == '1) ? r_evicts : r_evicts + TW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sac_pkg::B_SCAN) begin
            if (rd_en) begin
                r_rd_way <= r_rd_way + WAY_CNT_W'(1);
            end
            r_chk_way <= r_rd_way;
            if (r_rd_vld) begin
                // first matching way wins
                if (!r_hit && rd_valid_bit && rd_tag == q_tag) begin
                    r_hit     <= 1'b1;
                    r_hit_way <= r_chk_way;
                end
                // strict compare keeps the lowest way on a tie
                if (r_chk_way == '0 || rd_stamp < r_vic_stamp) begin
                    r_vic_way   <= r_chk_way;
                    r_vic_stamp <= rd_stamp;
                    r_vic_valid <= rd_valid_bit;
                end
            end
        end else if (r_state != sac_pkg::B_WRITE || commit) begin
            // scan result is held while the write waits on the output
            r_rd_way <= '0;
            r_hit    <= 1'b0;
        end
        if (commit) begin
            r_o_hit   <= r_hit;
            r_o_evict <= !r_hit && r_vic_valid;
            r_o_last  <= !q_twice || r_pass;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.hit            = r_o_hit;
    assign o_out.miss           = !r_o_hit;
    assign o_out.evicted        = r_o_evict;
    assign o_out.last           = r_o_last;
    assign o_out.hit_total      = r_hits;
    assign o_out.miss_total     = r_misses;
    assign o_out.eviction_total = r_evicts;

endmodule

[rtl/set_assoc_cache_lru_model_top.sv]
// Tag store of a set-associative cache with LRU replacement. Each load or store
// access word yields one result word, a modify yields two with the second marked
// last. After reset the tag memory is swept clean, one line per cycle, all
// MAX_SETS*MAX_WAYS lines (2048 at the defaults), before the first access word
// is taken; configuration writes are taken at any time but must only be issued
// while the block is idle. The front end takes a word only in its idle state,
// splitting the address, and passes it through its MOD and PUSH states before
// it takes the next; when MAX_SETS is not a power of two it reduces the set
// index with a reciprocal multiply, a subtraction and a correction. A two-entry
// queue hands the word to the back end. The back end reads the ways of the set
// one per cycle from the tag memory, so an access costs more with more ways in
// use and a modify scans the set twice; the back end usually sets the pace.
module set_assoc_cache_lru_model_top #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sac_in_if.sink   i_in,
    sac_cfg_if.sink  i_cfg,
    sac_out_if.source o_out
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ENT_W = 1 + ADDR_WIDTH + SET_W;

    sac_pkg::t_cfg    r_cfg;
    logic             push, push_ready, q_valid, pop, clearing;
    logic [ENT_W-1:0] push_data, q_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= 4'd4;
            r_cfg.block_bits <= 6'd4;
            r_cfg.ways_used  <= 4'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sac_pkg::REG_SET_BITS:   r_cfg.set_bits   <= i_cfg.data[3:0];
                sac_pkg::REG_BLOCK_BITS: r_cfg.block_bits <= i_cfg.data;
                sac_pkg::REG_WAYS_USED:  r_cfg.ways_used  <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    sac_front #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .MAX_SETS   (MAX_SETS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .i_block      (clearing),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    sac_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (push_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    sac_back #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule

[rtl/sac_checker.sv]
`include "set_assoc_cache_lru_model_top_assert.svh"

module sac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_hit,
    input logic        i_miss,
    input logic        i_evicted,
    input logic [31:0] i_miss_total,
    input logic [31:0] i_eviction_total
);

    `SAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped while stalled")
    `SAC_ASSERT_NOW(a_hit_xor_miss, i_clk, i_rst_n, i_out_valid, i_hit != i_miss, "hit and miss not exclusive")
    `SAC_ASSERT_NOW(a_evict_on_miss, i_clk, i_rst_n, i_out_valid && i_evicted, i_miss, "eviction without miss")
    `SAC_ASSERT_NOW(a_evict_le_miss, i_clk, i_rst_n, i_out_valid, i_eviction_total <= i_miss_total, "more evictions than misses")

endmodule

bind set_assoc_cache_lru_model_top sac_checker u_sac_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_hit            (o_out.hit),
    .i_miss           (o_out.miss),
    .i_evicted        (o_out.evicted),
    .i_miss_total     (o_out.miss_total),
    .i_eviction_total (o_out.eviction_total)
);

[tb/sv/tb_set_assoc_cache_lru_model_top.sv]
module tb_set_assoc_cache_lru_model_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS   = 256;
    localparam int NWAYS   = 8;
    localparam int IDLE_WAIT = 60;    // wait in drain after the last expected result
    localparam int WDOG_LIMIT = 20000; // longer than the clearing sweep after reset
    localparam logic [sac_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic       hit;
        logic       miss;
        logic       evicted;
        logic       last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } t_outcome;

    class lru_scoreboard;
        logic [3:0]  set_bits;
        logic [5:0]  block_bits;
        logic [3:0]  ways_used;
        logic        line_valid [NSETS*NWAYS];
        logic [63:0] line_tag [NSETS*NWAYS];
        logic [63:0] line_stamp [NSETS*NWAYS];
        logic [63:0] stamp_now;
        logic [31:0] hits, misses, evicts;
        t_outcome    outcome_q[$];
        int          errors;
        int          results_seen;
        int          hit_seen;
        int          evict_seen;

        function new();
            set_bits = 4;
            block_bits = 4;
            ways_used = 1;
            for (int i = 0; i < NSETS*NWAYS; i++) begin
                line_valid[i] = 0;
                line_tag[i] = '0;
                line_stamp[i] = '0;
            end
            stamp_now = 1;
            hits = 0;
            misses = 0;
            evicts = 0;
            errors = 0;
            results_seen = 0;
            hit_seen = 0;
            evict_seen = 0;
        endfunction

        function void write_reg(logic [sac_pkg::CFG_IDX_W-1:0] idx,
                                logic [sac_pkg::CFG_DATA_W-1:0] data);
            if (idx == sac_pkg::REG_SET_BITS) set_bits = data[3:0];
            else if (idx == sac_pkg::REG_BLOCK_BITS) block_bits = data;
            else if (idx == sac_pkg::REG_WAYS_USED) ways_used = data[3:0];
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == '1) ? v : v + 1;
        endfunction

        function void lookup(logic [63:0] addr, logic last);
            logic [63:0] above, setidx, tag;
            int          ways, base, victim;
            t_outcome    o;
            above = addr >> block_bits;
            setidx = (above & ((64'd1 << set_bits) - 1)) % NSETS;
            tag = (int'(set_bits) + int'(block_bits) < 64) ?
                  addr >> (set_bits + block_bits) : '0;
            ways = (ways_used == 0) ? 1 : (ways_used > NWAYS ? NWAYS : ways_used);
            base = int'(setidx) * NWAYS;
            o.hit = 0;
            o.evicted = 0;
            for (int i = 0; i < ways; i++) begin
                if (!o.hit && line_valid[base+i] && line_tag[base+i] == tag) begin
                    line_stamp[base+i] = stamp_now;
                    stamp_now++;
                    hits = sat_inc(hits);
                    o.hit = 1;
                end
            end
            if (!o.hit) begin
                misses = sat_inc(misses);
                victim = 0;
                for (int i = 1; i < ways; i++)
                    if (line_stamp[base+i] < line_stamp[base+victim]) victim = i;
                if (line_valid[base+victim]) begin
                    o.evicted = 1;
                    evicts = sat_inc(evicts);
                end
                line_valid[base+victim] = 1;
                line_tag[base+victim] = tag;
                line_stamp[base+victim] = stamp_now;
                stamp_now++;
            end
            o.miss = !o.hit;
            o.last = last;
            o.hit_total = hits;
            o.miss_total = misses;
            o.evict_total = evicts;
            outcome_q.push_back(o);
        endfunction

        function void note_access(logic [sac_pkg::OP_W-1:0] op, logic [63:0] addr);
            if (op == sac_pkg::OP_LOAD || op == sac_pkg::OP_STORE) begin
                lookup(addr, 1);
            end else if (op == sac_pkg::OP_MODIFY) begin
                lookup(addr, 0);
                lookup(addr, 1);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
            errors++;
        endtask

        task check_result(t_outcome r);
            t_outcome e;
            results_seen++;
            if (outcome_q.size() == 0) begin
                report("unexpected result word", 32'd1, 32'd0);
            end else begin
                e = outcome_q.pop_front();
                if (e.hit) hit_seen++;
                if (e.evicted) evict_seen++;
                if (r.hit !== e.hit) report("hit", r.hit, e.hit);
                if (r.miss !== e.miss) report("miss", r.miss, e.miss);
                if (r.evicted !== e.evicted) report("evicted", r.evicted, e.evicted);
                if (r.last !== e.last) report("last", r.last, e.last);
                if (r.hit_total !== e.hit_total) report("hit_total", r.hit_total, e.hit_total);
                if (r.miss_total !== e.miss_total)
                    report("miss_total", r.miss_total, e.miss_total);
                if (r.evict_total !== e.evict_total)
                    report("eviction_total", r.evict_total, e.evict_total);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    sac_in_if  in_ch();
    sac_cfg_if cfg_ch();
    sac_out_if out_ch();

    set_assoc_cache_lru_model_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .i_cfg(cfg_ch.sink),
        .o_out(out_ch.source)
    );

    lru_scoreboard sb = new();
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  hold_request = 0;
    bit  hold_done = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // accepted words go to the scoreboard, accepted result words are checked
    always @(posedge i_clk) begin
        t_outcome r;
        if (i_rst_n && in_ch.valid && in_ch.ready) sb.note_access(in_ch.op, in_ch.address);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.hit = out_ch.hit;
            r.miss = out_ch.miss;
            r.evicted = out_ch.evicted;
            r.last = out_ch.last;
            r.hit_total = out_ch.hit_total;
            r.miss_total = out_ch.miss_total;
            r.evict_total = out_ch.eviction_total;
            sb.check_result(r);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: free-running stretches, random stalls, and one long hold-off
    initial begin
        int stretch;
        bit choppy;
        out_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                @(negedge i_clk);
                out_ch.ready <= 0;
                repeat (400) @(negedge i_clk);
                hold_done = 1;
            end
            stretch = $urandom_range(5, 60);
            choppy = 1'($urandom_range(0, 1));
            repeat (stretch) begin
                @(negedge i_clk);
                out_ch.ready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    task automatic send_word(logic [sac_pkg::OP_W-1:0] op, logic [63:0] addr);
        @(negedge i_clk);
        in_ch.valid <= 1;
        in_ch.op <= op;
        in_ch.address <= addr;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic sender_gap();
        int gap;
        if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            in_ch.valid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_cfg(logic [sac_pkg::CFG_IDX_W-1:0] idx,
                             logic [sac_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_geometry(logic [3:0] sbits, logic [5:0] bbits, logic [3:0] ways);
        write_cfg(sac_pkg::REG_SET_BITS, {2'b00, sbits});
        write_cfg(sac_pkg::REG_BLOCK_BITS, bbits);
        write_cfg(sac_pkg::REG_WAYS_USED, {2'b00, ways});
    endtask

    // mostly addresses built from a few tags per set so sets fill and evict
    function automatic logic [63:0] pick_address();
        logic [63:0] a, tag, set;
        int sh;
        if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
        sh = sb.set_bits + sb.block_bits;
        tag = 64'($urandom_range(0, 11));
        if ($urandom_range(0, 9) == 0) tag = {$urandom, $urandom};
        set = 64'($urandom_range(0, 7));
        a = (sh < 64) ? (tag << sh) : '0;
        a |= (set << sb.block_bits) & ~(64'hFFFF_FFFF_FFFF_FFFF << sh);
        a |= {$urandom, $urandom} & ~(64'hFFFF_FFFF_FFFF_FFFF << sb.block_bits);
        return a;
    endfunction

    function automatic logic [sac_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return sac_pkg::OP_NONE;
        if (r < 8) return sac_pkg::OP_LOAD;
        if (r < 14) return sac_pkg::OP_STORE;
        return sac_pkg::OP_MODIFY;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            send_word(pick_op(), pick_address());
            if (i == count / 2 && $urandom_range(0, 2) == 0) drain();
            else sender_gap();
        end
        drain();
    endtask

    initial begin
        in_ch.valid = 0;
        in_ch.op = sac_pkg::OP_LOAD;
        in_ch.address = '0;
        cfg_ch.valid = 0;
        cfg_ch.index = sac_pkg::REG_SET_BITS;
        cfg_ch.data = '0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset geometry, all ops, address extremes, repeats
        send_word(sac_pkg::OP_LOAD, 64'h0);
        send_word(sac_pkg::OP_STORE, 64'h0);
        send_word(sac_pkg::OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(sac_pkg::OP_NONE, 64'h1234);
        send_word(sac_pkg::OP_LOAD, 64'h100);
        send_word(sac_pkg::OP_LOAD, 64'h0);
        send_word(sac_pkg::OP_MODIFY, 64'h8000_0000_0000_0010);
        drain();
        // zero ways acts as one, bad register index ignored, wide shifts
        set_geometry(4'd15, 6'd63, 4'd0);
        write_cfg(REG_UNUSED, 6'h3F);
        send_word(sac_pkg::OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(sac_pkg::OP_STORE, 64'h0);
        send_word(sac_pkg::OP_MODIFY, 64'h5555_5555_5555_5555);
        drain();
        set_geometry(4'd15, 6'd0, 4'd15);
        for (int i = 0; i < 10; i++)
            send_word(sac_pkg::OP_LOAD, {55'd0, i[0], 8'h42} | (64'(i) << 20));
        send_word(sac_pkg::OP_LOAD, 64'h0000_0000_0001_0042);
        drain();
        set_geometry(4'd0, 6'd32, 4'd8);
        send_word(sac_pkg::OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(sac_pkg::OP_LOAD, 64'hAAAA_AAAA_0000_0000);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_geometry(4'd0, 6'd0, 4'd1);
                1: set_geometry(4'd8, 6'd32, 4'd8);
                2: set_geometry(4'd2, 6'd3, 4'd4);
                3: set_geometry(4'd4, 6'd4, 4'd15);
                4: set_geometry(4'd1, 6'd6, 4'd2);
                default: begin
                    set_geometry(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                                 4'($urandom_range(0, 15)));
                    if (ph == 7) write_cfg(REG_UNUSED, 6'($urandom_range(0, 63)));
                end
            endcase
            if (ph == 3) hold_request = 1;
            random_phase(150);
        end

        $display("ran %0d access words across 14 cache geometries, %0d results checked",
                 items_sent, sb.results_seen);
        $display("hits %0d, evictions %0d", sb.hit_seen, sb.evict_seen);
        if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[set_assoc_cache_lru_model_top.f]
+incdir+rtl
rtl/sac_pkg.sv
rtl/sac_if.sv
rtl/sac_queue.sv
rtl/sac_front.sv
rtl/sac_back.sv
rtl/set_assoc_cache_lru_model_top.sv
rtl/sac_checker.sv
tb/sv/tb_set_assoc_cache_lru_model_top.sv
